// ----- src/tbsq_pkg.sv -----
package tbsq_pkg;

   localparam int NUM_LANES = 4;
   localparam int CODE_W    = 2;
   localparam int SAMPLE_W  = 8;
   localparam int STAT_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int PACKED_W  = NUM_LANES * CODE_W;

   // round(0.98159883 * 2^24) in unsigned Q0.24, and one half for rounding
   localparam logic [23:0] THR_FACTOR = 24'd16468496;
   localparam logic [23:0] THR_ROUND  = 24'd8388608;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEAN_POL0   = 3'd0,
      CSR_MEAN_POL1   = 3'd1,
      CSR_SPREAD_POL0 = 3'd2,
      CSR_SPREAD_POL1 = 3'd3,
      CSR_SINGLE_POL  = 3'd4
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_HIGH     = 2'd0,
      CODE_POS      = 2'd1,
      CODE_NEG      = 2'd2,
      CODE_LOW      = 2'd3
   } code_type;

   typedef struct packed {
      logic signed [STAT_W-1:0] mean;
      logic        [STAT_W-1:0] thr;
   } pol_stat_type;

   typedef logic [CODE_W-1:0] code_vec_type [NUM_LANES];

   // thr = round(0.98159883 * spread), never above 64330
   function automatic logic [STAT_W-1:0] threshold_of(input logic [STAT_W-1:0] spread);
      logic [40:0] prod;
      prod = 41'(spread) * 41'(THR_FACTOR) + 41'(THR_ROUND);
      return prod[39:24];
   endfunction

endpackage

// ----- src/tbsq_lane.sv -----
module tbsq_lane
   import tbsq_pkg::*;
(
   input  logic signed [SAMPLE_W-1:0] sample,
   input  pol_stat_type               stat,
   output logic        [CODE_W-1:0]   code
);

   logic signed [STAT_W+1:0] diff;
   logic signed [STAT_W+1:0] thr_pos;
   logic signed [STAT_W+1:0] thr_neg;

   // sample in Q8.8 minus mean, 18 bits signed
   assign diff    = (STAT_W+2)'($signed({sample, 8'h00})) - (STAT_W+2)'(stat.mean);
   assign thr_pos = $signed({2'b00, stat.thr});
   assign thr_neg = -thr_pos;

   always_comb begin
      if (diff > thr_pos) begin
         code = CODE_HIGH;
      end else if (diff > (STAT_W+2)'(0)) begin
         code = CODE_POS;
      end else if (diff > thr_neg) begin
         code = CODE_NEG;
      end else begin
         code = CODE_LOW;
      end
   end

endmodule

// ----- src/tbsq_merge.sv -----
module tbsq_merge
   import tbsq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  code_vec_type        in_codes,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [PACKED_W-1:0] out_packed
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [PACKED_W-1:0] main_packed_ff, main_packed_in;
   logic [PACKED_W-1:0] skid_packed_ff, skid_packed_in;
   logic [PACKED_W-1:0] packed_now;
   logic                in_accept;
   logic                out_take;

   // first lane in the low bits
   always_comb begin
      packed_now = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         packed_now[i*CODE_W +: CODE_W] = in_codes[i];
      end
   end

   assign in_stall  = skid_valid_ff;
   assign in_accept = in_valid && !skid_valid_ff;
   assign out_take  = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in  = main_valid_ff;
      main_packed_in = main_packed_ff;
      skid_valid_in  = skid_valid_ff;
      skid_packed_in = skid_packed_ff;
      if (!main_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            // advance the held request; skid was full so nothing new came in
            main_valid_in  = 1'b1;
            main_packed_in = skid_packed_ff;
            skid_valid_in  = 1'b0;
         end else begin
            main_valid_in  = in_accept;
            main_packed_in = packed_now;
         end
      end else if (in_accept) begin
         // output stalled: park the request
         skid_valid_in  = 1'b1;
         skid_packed_in = packed_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_packed_ff <= main_packed_in;
      skid_packed_ff <= skid_packed_in;
   end

   assign out_valid  = main_valid_ff;
   assign out_packed = main_packed_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds a request while output register is empty");

   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_accept && main_valid_ff && out_stall) |=> skid_valid_ff)
      else $error("request accepted under output stall was not parked");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_stall) |=> (skid_valid_ff && $stable(skid_packed_ff)))
      else $error("parked request lost while output stalled");

   a_skid_refills: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_take) |=>
         (main_valid_ff && main_packed_ff == $past(skid_packed_ff)))
      else $error("parked request did not move to output register");

endmodule

// ----- src/two_bit_sample_quantizer.sv -----
// Two-bit four-level quantizer: each request carries two samples of each
// polarization; four lanes compare sample*256 - mean against +/-threshold in
// parallel and the merge stage packs the codes (pol0_first in bits 1:0) into
// one byte. Thresholds (0.98159883 * spread, rounded) are computed when a
// spread register is written, so requests may follow a write on the next
// cycle. Throughput is one request per cycle unless rsp_stall holds it;
// results are registered; a skid stage keeps accepting one request while the
// result channel stalls. Write statistics only while no request is in flight.
module two_bit_sample_quantizer
   import tbsq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [STAT_W-1:0]           csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_pol0_first,
   input  logic signed [SAMPLE_W-1:0]  req_pol0_second,
   input  logic signed [SAMPLE_W-1:0]  req_pol1_first,
   input  logic signed [SAMPLE_W-1:0]  req_pol1_second,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [PACKED_W-1:0]         rsp_packed_codes
);

   logic signed [STAT_W-1:0] mean0_ff, mean1_ff;
   logic        [STAT_W-1:0] thr0_ff, thr1_ff;
   logic                     single_ff;
   logic        [STAT_W-1:0] thr_wdata;
   pol_stat_type             stat0, stat1;
   logic signed [SAMPLE_W-1:0] samples [NUM_LANES];
   code_vec_type             codes;

   assign thr_wdata = threshold_of(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         mean0_ff  <= '0;
         mean1_ff  <= '0;
         thr0_ff   <= '0;
         thr1_ff   <= '0;
         single_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_MEAN_POL0:   mean0_ff  <= csr_wdata;
            CSR_MEAN_POL1:   mean1_ff  <= csr_wdata;
            CSR_SPREAD_POL0: thr0_ff   <= thr_wdata;
            CSR_SPREAD_POL1: thr1_ff   <= thr_wdata;
            CSR_SINGLE_POL:  single_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign stat0.mean = mean0_ff;
   assign stat0.thr  = thr0_ff;
   assign stat1.mean = single_ff ? mean0_ff : mean1_ff;
   assign stat1.thr  = single_ff ? thr0_ff  : thr1_ff;

   assign samples[0] = req_pol0_first;
   assign samples[1] = req_pol0_second;
   assign samples[2] = req_pol1_first;
   assign samples[3] = req_pol1_second;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      tbsq_lane u_lane (
         .sample (samples[g]),
         .stat   ((g < NUM_LANES/2) ? stat0 : stat1),
         .code   (codes[g])
      );
   end

   tbsq_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_codes   (codes),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_packed (rsp_packed_codes)
   );

endmodule

// ----- dv/two_bit_sample_quantizer_tb.sv -----
module two_bit_sample_quantizer_tb;
   import tbsq_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DIRECTED_ROWS   = 32;
   localparam int RANDOM_PHASES   = 9;
   localparam int PHASE_REQUESTS  = 105;
   localparam int MAX_REPORTS     = 20;

   // indexes past the last register: writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_MID = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] pol0_first;
      logic signed [SAMPLE_W-1:0] pol0_second;
      logic signed [SAMPLE_W-1:0] pol1_first;
      logic signed [SAMPLE_W-1:0] pol1_second;
   } sample_set_type;

   typedef enum bit {ROW_WRITE, ROW_SEND} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [STAT_W-1:0]     wdata;
      sample_set_type        smp;
      bit                    lit_on;
      logic [PACKED_W-1:0]   lit;
   } plan_row_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_wen;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [STAT_W-1:0]           csr_wdata;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_pol0_first;
   logic signed [SAMPLE_W-1:0]  req_pol0_second;
   logic signed [SAMPLE_W-1:0]  req_pol1_first;
   logic signed [SAMPLE_W-1:0]  req_pol1_second;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [PACKED_W-1:0]         rsp_packed_codes;

   // shadow copy of the statistics registers
   logic signed [STAT_W-1:0]    mean_p0;
   logic signed [STAT_W-1:0]    mean_p1;
   logic [STAT_W-1:0]           spread_p0;
   logic [STAT_W-1:0]           spread_p1;
   logic                        single_mode;

   logic [PACKED_W-1:0]         codes_pending [$];
   bit                          lit_armed;
   logic [PACKED_W-1:0]         lit_value;
   bit                          req_gaps_on;
   bit                          rsp_gaps_on;
   int                          stall_left;
   int                          idle_cycles;
   int                          mismatch_count;
   int                          requests_sent;
   int                          results_checked;
   int                          phases_run;
   plan_row_type                directed_plan [DIRECTED_ROWS];

   two_bit_sample_quantizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pol0_first   (req_pol0_first),
      .req_pol0_second  (req_pol0_second),
      .req_pol1_first   (req_pol1_first),
      .req_pol1_second  (req_pol1_second),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_codes (rsp_packed_codes)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // round(0.98159883 * spread), half up, in Q8.8
   function automatic int threshold_for(logic [STAT_W-1:0] spread);
      longint unsigned prod;
      prod = longint'(spread) * longint'(THR_FACTOR) + longint'(THR_ROUND);
      return int'(prod >> 24);
   endfunction

   function automatic code_type level_of(logic signed [SAMPLE_W-1:0] s,
                                         logic signed [STAT_W-1:0] m, int thr);
      int d;
      d = int'(s) * 256 - int'(m);
      if (d > thr) return CODE_HIGH;
      if (d > 0) return CODE_POS;
      if (d > -thr) return CODE_NEG;
      return CODE_LOW;
   endfunction

   function automatic logic [PACKED_W-1:0] packed_codes_for(sample_set_type x);
      logic signed [STAT_W-1:0] m1;
      int t0;
      int t1;
      m1 = single_mode ? mean_p0 : mean_p1;
      t0 = threshold_for(spread_p0);
      t1 = threshold_for(single_mode ? spread_p0 : spread_p1);
      return {level_of(x.pol1_second, m1, t1), level_of(x.pol1_first, m1, t1),
              level_of(x.pol0_second, mean_p0, t0), level_of(x.pol0_first, mean_p0, t0)};
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_W-1:0] index,
                                            logic [STAT_W-1:0] data);
      plan_row_type r;
      r.kind   = ROW_WRITE;
      r.index  = index;
      r.wdata  = data;
      r.smp    = '0;
      r.lit_on = 1'b0;
      r.lit    = '0;
      return r;
   endfunction

   function automatic plan_row_type req_row(int a, int b, int c, int d, bit lit_on = 1'b0,
                                            logic [PACKED_W-1:0] lit = '0);
      plan_row_type r;
      r.kind   = ROW_SEND;
      r.index  = '0;
      r.wdata  = '0;
      r.smp    = {SAMPLE_W'(a), SAMPLE_W'(b), SAMPLE_W'(c), SAMPLE_W'(d)};
      r.lit_on = lit_on;
      r.lit    = lit;
      return r;
   endfunction

   // half full range, half clustered around the mean, out to two steps past the threshold
   function automatic logic [SAMPLE_W-1:0] pick_sample(logic signed [STAT_W-1:0] m, int thr);
      int v;
      if ($urandom_range(0, 1) == 0) return SAMPLE_W'($urandom_range(0, 255));
      v = (int'(m) >>> 8) + int'($urandom_range(0, 2 * (thr >> 8) + 4)) - (thr >> 8) - 2;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return SAMPLE_W'(v);
   endfunction

   function automatic sample_set_type random_request();
      logic signed [STAT_W-1:0] m1;
      int t0;
      int t1;
      m1 = single_mode ? mean_p0 : mean_p1;
      t0 = threshold_for(spread_p0);
      t1 = threshold_for(single_mode ? spread_p0 : spread_p1);
      return {pick_sample(mean_p0, t0), pick_sample(mean_p0, t0),
              pick_sample(m1, t1), pick_sample(m1, t1)};
   endfunction

   function automatic logic [STAT_W-1:0] pick_spread();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return STAT_W'($urandom);
         default: return STAT_W'($urandom_range(0, 16'h0C00));
      endcase
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [STAT_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_MEAN_POL0:   mean_p0 = data;
         CSR_MEAN_POL1:   mean_p1 = data;
         CSR_SPREAD_POL0: spread_p0 = data;
         CSR_SPREAD_POL1: spread_p1 = data;
         CSR_SINGLE_POL:  single_mode = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid and hold until every request has produced its result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (codes_pending.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_request(sample_set_type x, bit lit_on, logic [PACKED_W-1:0] lit);
      lit_armed = lit_on;
      lit_value = lit;
      req_valid <= 1'b1;
      {req_pol0_first, req_pol0_second, req_pol1_first, req_pol1_second} <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      @(negedge clock);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic randomize_stats();
      write_csr(CSR_MEAN_POL0, STAT_W'($urandom));
      write_csr(CSR_MEAN_POL1, STAT_W'($urandom));
      write_csr(CSR_SPREAD_POL0, pick_spread());
      write_csr(CSR_SPREAD_POL1, pick_spread());
      write_csr(CSR_SINGLE_POL, STAT_W'($urandom));
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), STAT_W'($urandom));
   endtask

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (reset || !rsp_gaps_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 12) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic [PACKED_W-1:0] want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall)
            codes_pending.push_back(lit_armed ? lit_value : packed_codes_for(
               {req_pol0_first, req_pol0_second, req_pol1_first, req_pol1_second}));
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (codes_pending.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: packed_codes expected none actual %02h",
                           $time, rsp_packed_codes);
            end else begin
               want = codes_pending.pop_front();
               if (rsp_packed_codes !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: packed_codes expected %02h actual %02h",
                              $time, want, rsp_packed_codes);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("two_bit_sample_quantizer: mismatch");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      csr_wen         = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_pol0_first  = '0;
      req_pol0_second = '0;
      req_pol1_first  = '0;
      req_pol1_second = '0;
      rsp_stall       = 1'b0;
      lit_armed       = 1'b0;
      lit_value       = '0;
      req_gaps_on     = 1'b1;
      rsp_gaps_on     = 1'b1;
      mean_p0         = '0;
      mean_p1         = '0;
      spread_p0       = '0;
      spread_p1       = '0;
      single_mode     = 1'b0;

      directed_plan = '{
         // zero spread after reset: only d > 0 vs. everything else
         req_row(0, 0, 0, 0, 1'b1, 8'hFF),
         req_row(127, 127, 127, 127, 1'b1, 8'h00),
         req_row(-128, -128, -128, -128, 1'b1, 8'hFF),
         req_row(1, 0, -1, 127, 1'b1, 8'h3C),
         csr_row(CSR_MEAN_POL0, 16'h0A00),
         csr_row(CSR_MEAN_POL1, 16'hF600),
         csr_row(CSR_SPREAD_POL0, 16'h0500),
         csr_row(CSR_SPREAD_POL1, 16'h0280),
         // every sample sits exactly on its mean
         req_row(10, 10, -10, -10, 1'b1, 8'hAA),
         // means chosen so d lands on +thr for pol0 and -thr for pol1
         csr_row(CSR_MEAN_POL0, 16'h0518),
         csr_row(CSR_MEAN_POL1, 16'h0274),
         req_row(10, 0, 0, 5),
         req_row(5, 127, 1, 3),
         req_row(-128, 11, -1, 0),
         req_row(9, 10, 2, 127),
         req_row(85, -86, -43, 42),
         csr_row(CSR_MEAN_POL0, 16'h7FFF),
         csr_row(CSR_SPREAD_POL0, 16'hFFFF),
         csr_row(CSR_MEAN_POL1, 16'h8000),
         csr_row(CSR_SPREAD_POL1, 16'h0000),
         req_row(127, -128, 127, -128),
         req_row(0, 64, -128, -127),
         req_row(1, -1, 0, 0),
         // upper data bits of the mode register must be dropped
         csr_row(CSR_SINGLE_POL, 16'hFFFF),
         req_row(127, -128, 127, -128),
         req_row(3, -3, -128, 126),
         csr_row(CSR_SPARE_LO, 16'hFFFF),
         csr_row(CSR_SPARE_MID, 16'h1234),
         csr_row(CSR_SPARE_HI, 16'h8000),
         req_row(3, -3, -128, 126),
         csr_row(CSR_SINGLE_POL, 16'hFFFE),
         req_row(20, -20, -128, 127)
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            drain_results();
            write_csr(directed_plan[i].index, directed_plan[i].wdata);
         end else begin
            send_request(directed_plan[i].smp, directed_plan[i].lit_on, directed_plan[i].lit);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         randomize_stats();
         // every third phase and the last one run without gaps
         req_gaps_on = (p % 3 != 2) && (p != RANDOM_PHASES - 1);
         rsp_gaps_on = req_gaps_on;
         phases_run++;
         repeat (PHASE_REQUESTS) begin
            if ($urandom_range(0, 79) == 0) drain_results();
            send_request(random_request(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (4) @(posedge clock);

      $display("%0d requests (%0d directed rows), %0d results checked, %0d random stat sets",
               requests_sent, DIRECTED_ROWS, results_checked, phases_run);
      $display("covered zero/full-scale spreads, extreme means, single-pol mode, spare indexes");
      if (mismatch_count == 0 && codes_pending.size() == 0)
         $display("two_bit_sample_quantizer: match");
      else
         $display("two_bit_sample_quantizer: mismatch");
      $finish;
   end

endmodule
